/* rtl/core/czrp_pkg.sv */
package czrp_pkg;

   localparam int PLANE_BYTES  = 64;
   localparam int BLOCK_BYTES  = 2 * PLANE_BYTES;
   localparam int POS_W        = $clog2(BLOCK_BYTES);
   localparam int GROUP_VALUES = 3;
   localparam int GROUP_BYTES  = GROUP_VALUES + 1;
   localparam int FRAME_BYTES  = 6;
   localparam int CNT_W        = $clog2(FRAME_BYTES + 1);
   localparam int RUN_LIMIT    = 63;
   localparam int WORD_BYTES   = 4;

   typedef logic [7:0]       byte_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [1:0]       vcnt_type;
   typedef logic [5:0]       zcnt_type;
   typedef logic [CNT_W-1:0] fcnt_type;

endpackage

/* rtl/core/coefficient_zero_run_packer.sv */
// Packs one block of signed coefficient bytes (64 luma, plus 64 chroma when
// the color bit is set) into zero-run groups: a header byte (value count * 64
// + zero count) followed by up to three raw values. Each accepted item goes
// through the dead zone and the group logic and lands in a registered result
// frame of 0 to 6 bytes, which the rsp channel drains one byte per cycle
// while rsp_ready is high. A new item enters only once the frame is empty or
// its last byte is being taken, so the single output byte port sets the rate.
// run_last marks the last byte of an item, block_last the final byte of the
// block. csr_write_data must be written only while idle; the block itself
// does not enforce it.
module coefficient_zero_run_packer
   import czrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_coefficient,
   input  logic [6:0] req_loss,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_run_last,
   output logic       rsp_block_last
);

   logic     color_ff;
   logic     in_valid_ff;
   byte_type coef_ff;
   logic [6:0] loss_ff;

   pos_type  pos_ff, pos_in;
   logic     zp_ff, zp_in;
   vcnt_type vc_ff, vc_in;
   zcnt_type zc_ff, zc_in;
   byte_type buf_ff [GROUP_VALUES];
   byte_type buf_in [GROUP_VALUES];

   byte_type frm_ff [FRAME_BYTES];
   byte_type frm_in [FRAME_BYTES];
   fcnt_type cnt_ff, cnt_in;
   logic     blk_ff, blk_in;

   logic     advance;
   logic     rsp_take;

   assign rsp_valid      = cnt_ff != '0;
   assign rsp_take       = rsp_valid && rsp_ready;
   assign advance        = in_valid_ff && (cnt_ff == '0 || (cnt_ff == fcnt_type'(1) && rsp_ready));
   assign req_ready      = !in_valid_ff || advance;
   assign rsp_data_byte  = frm_ff[0];
   assign rsp_run_last   = cnt_ff == fcnt_type'(1);
   assign rsp_block_last = rsp_run_last && blk_ff;

   always_comb begin
      pos_type      plane;
      logic         chroma;
      logic         exempt;
      logic         last;
      logic [7:0]   thr;
      logic signed [9:0] v10;
      logic signed [9:0] t10;
      byte_type     b;
      logic         c1;
      logic [6:0]   run_sum;
      byte_type     grp_a [GROUP_BYTES];
      byte_type     grp_b [GROUP_BYTES];
      fcnt_type     a_len;
      fcnt_type     b_len;
      fcnt_type     slot;

      plane  = (pos_ff >= pos_type'(PLANE_BYTES)) ? pos_ff - pos_type'(PLANE_BYTES) : pos_ff;
      chroma = color_ff && (pos_ff >= pos_type'(PLANE_BYTES));
      exempt = plane == pos_type'(0) || plane == pos_type'(1) ||
               plane == pos_type'(8) || plane == pos_type'(9);
      if (color_ff) begin
         last = pos_ff >= pos_type'(BLOCK_BYTES - 1);
      end else begin
         last = pos_ff >= pos_type'(PLANE_BYTES - 1);
      end
      thr = chroma ? {loss_ff, 1'b0} : {1'b0, loss_ff};
      v10 = {{2{coef_ff[7]}}, coef_ff};
      t10 = {2'b00, thr};
      b   = coef_ff;
      if (loss_ff != '0 && !exempt && v10 <= t10 && v10 >= -t10) begin
         b = '0;
      end

      c1      = 1'b0;
      zp_in   = zp_ff;
      vc_in   = vc_ff;
      zc_in   = zc_ff;
      buf_in  = buf_ff;
      run_sum = {1'b0, zc_ff} + 7'(WORD_BYTES) - {5'b0, pos_ff[1:0]};

      if (pos_ff == '0) begin
         buf_in[0] = b;
         vc_in     = 2'd1;
         zc_in     = '0;
         zp_in     = 1'b0;
      end else if (b != '0) begin
         if (zp_ff || vc_ff == vcnt_type'(GROUP_VALUES)) begin
            c1        = 1'b1;
            buf_in[0] = b;
            vc_in     = 2'd1;
            zc_in     = '0;
            zp_in     = 1'b0;
         end else begin
            buf_in[vc_ff] = b;
            vc_in         = vc_ff + 2'd1;
            if (vc_ff == vcnt_type'(GROUP_VALUES - 1)) begin
               zp_in = 1'b1;
            end
         end
      end else begin
         if (!zp_ff) begin
            zp_in = 1'b1;
            zc_in = 6'd1;
         end else if (run_sum >= 7'(RUN_LIMIT)) begin
            c1    = 1'b1;
            zp_in = 1'b1;
            zc_in = 6'd1;
            vc_in = '0;
         end else begin
            zc_in = zc_ff + 6'd1;
         end
      end

      grp_a[0] = {vc_ff, zc_ff};
      grp_b[0] = {vc_in, zc_in};
      for (int i = 0; i < GROUP_VALUES; i++) begin
         grp_a[i+1] = buf_ff[i];
         grp_b[i+1] = buf_in[i];
      end
      a_len = c1 ? fcnt_type'(vc_ff) + fcnt_type'(1) : '0;
      b_len = last ? fcnt_type'(vc_in) + fcnt_type'(1) : '0;

      for (int i = 0; i < FRAME_BYTES; i++) begin
         slot = fcnt_type'(i) - a_len;
         if (fcnt_type'(i) < a_len) begin
            frm_in[i] = grp_a[i[1:0]];
         end else begin
            frm_in[i] = grp_b[slot[1:0]];
         end
      end
      cnt_in = a_len + b_len;
      blk_in = last;

      if (last) begin
         pos_in = '0;
         zp_in  = 1'b0;
         vc_in  = '0;
         zc_in  = '0;
      end else begin
         pos_in = pos_ff + pos_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= 1'b0;
      end else if (csr_write_enable) begin
         color_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         coef_ff <= req_coefficient;
         loss_ff <= req_loss;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         zp_ff  <= 1'b0;
         vc_ff  <= '0;
         zc_ff  <= '0;
      end else if (advance) begin
         pos_ff <= pos_in;
         zp_ff  <= zp_in;
         vc_ff  <= vc_in;
         zc_ff  <= zc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         buf_ff <= buf_in;
      end
   end

   // load a new frame, else shift out the byte just taken
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (advance) begin
         cnt_ff <= cnt_in;
      end else if (rsp_take) begin
         cnt_ff <= cnt_ff - fcnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         frm_ff <= frm_in;
         blk_ff <= blk_in;
      end else if (rsp_take) begin
         for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            frm_ff[i] <= frm_ff[i+1];
         end
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= fcnt_type'(FRAME_BYTES))
      else $error("result frame count out of range");

   a_full_group_zero_phase: assert property (@(posedge clock) disable iff (reset)
      vc_ff == vcnt_type'(GROUP_VALUES) |-> zp_ff)
      else $error("full group not in zero phase");

   a_zero_phase_run: assert property (@(posedge clock) disable iff (reset)
      zp_ff && vc_ff != vcnt_type'(GROUP_VALUES) |-> zc_ff != '0)
      else $error("zero phase entered without a zero");

   a_block_end_rewind: assert property (@(posedge clock) disable iff (reset)
      advance && blk_in |=> pos_ff == '0 && vc_ff == '0 && !zp_ff)
      else $error("state not rewound after block end");

endmodule

/* tb/coefficient_zero_run_packer_test.sv */
`timescale 1ns / 1ps

module coefficient_zero_run_packer_test;
   import czrp_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;

   typedef enum {DENSE, CHROMA_MIX, ZERO_RUN} mix_type;

   typedef struct packed {
      logic [7:0]      coef;
      logic [6:0]      loss;
      int              n_typed;
      logic [0:5][7:0] typed;
   } coef_row_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       run_last;
      logic       block_last;
   } coded_byte_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic       csr_write_data;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_coefficient;
   logic [6:0] req_loss;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_run_last;
   logic       rsp_block_last;

   // packer state mirror
   logic     color_mode;
   pos_type  block_pos;
   logic     zero_phase;
   vcnt_type value_cnt;
   zcnt_type zero_run;
   byte_type held_values [GROUP_VALUES];
   byte_type group_stream [$];
   logic     block_ended;

   coded_byte_type pending_bytes [$];
   coef_row_type   live_row;
   int             fail_count   = 0;
   int             quiet_cycles = 0;
   int             idle_pct     = 0;
   int             stall_pct    = 0;
   int             random_items = 0;

   coef_row_type directed_rows [16] = '{
      '{8'h7f, 7'd0,    0, 48'h0},
      '{8'h80, 7'd127,  0, 48'h0},
      '{8'h01, 7'd0,    0, 48'h0},
      '{8'hff, 7'd0,    4, 48'hc0_7f_80_01_00_00},
      '{8'h05, 7'd5,    0, 48'h0},
      '{8'hfa, 7'd5,    2, 48'h41_ff_00_00_00_00},
      '{8'h7f, 7'd127,  0, 48'h0},
      '{8'h80, 7'd127,  2, 48'h41_fa_00_00_00_00},
      '{8'h03, 7'd127,  0, 48'h0},
      '{8'h00, 7'd0,    0, 48'h0},
      '{8'h01, 7'd1,    0, 48'h0},
      '{8'hff, 7'd1,    0, 48'h0},
      '{8'h02, 7'd1,    3, 48'h83_80_03_00_00_00},
      '{8'hfe, 7'd1,   -1, 48'h0},
      '{8'h7f, 7'd0,   -1, 48'h0},
      '{8'h80, 7'd0,    4, 48'hc0_02_fe_7f_00_00}
   };

   coefficient_zero_run_packer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_coefficient  (req_coefficient),
      .req_loss         (req_loss),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_block_last   (rsp_block_last)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic emit_group();
      int k;
      group_stream.push_back({value_cnt, zero_run});
      for (k = 0; k < value_cnt; k++) group_stream.push_back(held_values[k]);
      value_cnt  = '0;
      zero_run   = '0;
      zero_phase = 1'b0;
   endtask

   task automatic pack_coefficient(input logic [7:0] coef, input logic [6:0] loss);
      int       v;
      int       t;
      int       total;
      int       plane;
      int       rem;
      logic     chroma;
      logic     exempt;
      byte_type b;
      group_stream.delete();
      v      = $signed(coef);
      total  = color_mode ? 2 * PLANE_BYTES : PLANE_BYTES;
      plane  = block_pos % PLANE_BYTES;
      chroma = color_mode && (block_pos >= PLANE_BYTES);
      exempt = (plane == 0) || (plane == 1) || (plane == 8) || (plane == 9);
      rem    = WORD_BYTES - (block_pos % WORD_BYTES);
      block_ended = (block_pos + 1 >= total);
      if (loss != 0 && !exempt) begin
         t = chroma ? 2 * int'(loss) : int'(loss);
         if (v >= -t && v <= t) v = 0;
      end
      b = v[7:0];
      if (block_pos == 0) begin
         held_values[0] = b;
         value_cnt      = 2'd1;
         zero_run       = '0;
         zero_phase     = 1'b0;
      end else if (b != 0) begin
         if (zero_phase || value_cnt >= GROUP_VALUES) begin
            emit_group();
            held_values[0] = b;
            value_cnt      = 2'd1;
         end else begin
            held_values[value_cnt] = b;
            value_cnt++;
            if (value_cnt == GROUP_VALUES) zero_phase = 1'b1;
         end
      end else if (!zero_phase) begin
         zero_phase = 1'b1;
         zero_run   = 6'd1;
      end else if (zero_run + rem >= RUN_LIMIT) begin
         emit_group();
         zero_phase = 1'b1;
         zero_run   = 6'd1;
      end else begin
         zero_run++;
      end
      if (block_ended) begin
         emit_group();
         block_pos = '0;
      end else begin
         block_pos++;
      end
   endtask

   always @(posedge clock) begin
      coded_byte_type entry;
      int             k;
      if (reset) begin
         color_mode   = 1'b0;
         block_pos    = '0;
         zero_phase   = 1'b0;
         value_cnt    = '0;
         zero_run     = '0;
         quiet_cycles = 0;
      end else begin
         if (csr_write_enable) color_mode = csr_write_data;
         if (req_valid && req_ready) begin
            pack_coefficient(req_coefficient, req_loss);
            if (live_row.n_typed >= 0) begin
               group_stream.delete();
               for (k = 0; k < live_row.n_typed; k++) group_stream.push_back(live_row.typed[k]);
            end
            for (k = 0; k < group_stream.size(); k++) begin
               entry.data_byte  = group_stream[k];
               entry.run_last   = (k == group_stream.size() - 1);
               entry.block_last = entry.run_last && block_ended;
               pending_bytes.push_back(entry);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_bytes.size() == 0) begin
               flag_error($sformatf("byte %02h with nothing expected", rsp_data_byte));
            end else begin
               entry = pending_bytes.pop_front();
               if (rsp_data_byte !== entry.data_byte)
                  flag_error($sformatf("data_byte %02h, expected %02h",
                                       rsp_data_byte, entry.data_byte));
               if (rsp_run_last !== entry.run_last)
                  flag_error($sformatf("run_last %b, expected %b", rsp_run_last, entry.run_last));
               if (rsp_block_last !== entry.block_last)
                  flag_error($sformatf("block_last %b, expected %b",
                                       rsp_block_last, entry.block_last));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic offer_coefficient(input coef_row_type row);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      live_row = row;
      req_valid       <= 1'b1;
      req_coefficient <= row.coef;
      req_loss        <= row.loss;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_color(input logic enable);
      csr_write_enable <= 1'b1;
      csr_write_data   <= enable;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic feed_random(input mix_type mix, input int pos);
      coef_row_type row;
      int           span;
      int           c;
      case (random_items / 45)
         0: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         1: begin
            idle_pct  = 66;
            stall_pct = 0;
         end
         2: begin
            idle_pct  = 0;
            stall_pct = 66;
         end
         default: begin
            idle_pct  = 33;
            stall_pct = 33;
         end
      endcase
      // hold the sender until the packer has drained
      if (random_items == 120) settle();
      row.n_typed = -1;
      row.typed   = '0;
      case (mix)
         DENSE: begin
            c        = $urandom_range(1) ? 0 : int'($urandom_range(255));
            row.loss = ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom_range(40));
         end
         CHROMA_MIX: begin
            c        = ($urandom_range(9) < 3) ? 0 : int'($urandom_range(255));
            row.loss = ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom_range(127));
         end
         default: begin
            if (pos >= PLANE_BYTES) begin
               c        = 0;
               row.loss = 7'($urandom_range(127));
            end else if (pos < 2) begin
               c        = int'($urandom_range(255));
               row.loss = 7'($urandom_range(127));
            end else if (pos == 8 || pos == 9) begin
               c        = 0;
               row.loss = 7'($urandom_range(127));
            end else begin
               span     = int'($urandom_range(127, 1));
               c        = int'($urandom_range(2 * span)) - span;
               row.loss = 7'(span);
            end
         end
      endcase
      row.coef = c[7:0];
      random_items++;
      offer_coefficient(row);
   endtask

   initial begin
      int pos;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_coefficient  = '0;
      req_loss         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) offer_coefficient(directed_rows[i]);

      // grow the block mid-way: luma and chroma follow
      settle();
      write_color(1'b1);
      for (pos = 16; pos < PLANE_BYTES; pos++) feed_random(DENSE, pos);
      for (pos = PLANE_BYTES; pos < 2 * PLANE_BYTES; pos++) feed_random(CHROMA_MIX, pos);
      for (pos = 0; pos < PLANE_BYTES; pos++) feed_random(ZERO_RUN, pos);
      // shrink the block mid-way: the next item closes it
      settle();
      write_color(1'b0);
      feed_random(ZERO_RUN, PLANE_BYTES);
      settle();

      if (fail_count == 0 && pending_bytes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
